// File: rtl/signed_binary_to_decimal_ascii_defines.svh
// Assertion macros shared by the converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SBDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbda assertion failed");

// Check that cons holds in the cycle after ante.
`define SBDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbda assertion failed");

`endif

// File: rtl/sbda_pkg.sv
package sbda_pkg;

    localparam int VALUE_BITS    = 64;
    localparam int MAX_DIGITS    = 19;
    localparam int STEP_BITS     = 4;
    localparam int CONV_STEPS    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS      = CONV_STEPS * STEP_BITS;
    localparam int BCD_BITS      = MAX_DIGITS * 4;
    localparam int STEP_CNT_BITS = $clog2(CONV_STEPS);
    localparam int CNT_BITS      = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [BCD_BITS-1:0] bcd_t;

    typedef struct packed {
        logic ovf;
        bcd_t bcd;
    } unit_out_t;

endpackage

// File: rtl/signed_binary_to_decimal_ascii.sv
// Converts one signed value per transaction into its decimal ASCII text. A transaction is
// taken when start is high and busy is low; busy then stays high until the last character
// has been put out. A negative value first gives '-', on the cycle after the transaction.
// The magnitude is converted by a shift-and-add-3 unit that takes 4 bits a cycle; then the
// 19 digit positions are walked one a cycle, leading zeros dropped and the rest put out as
// characters. Each character is shown on out_char for a single cycle with out_valid high
// and must be taken then, since the receiver cannot stall the block; last_char marks the
// final character.
`include "signed_binary_to_decimal_ascii_defines.svh"

module signed_binary_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value,
    output logic        out_valid,
    output logic [7:0]  out_char,
    output logic        last_char
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int PB = sbda_pkg::PAD_BITS;
    localparam int SB = sbda_pkg::STEP_BITS;
    localparam int BB = sbda_pkg::BCD_BITS;

    logic [1:0]                         state_reg, state_next;
    logic [sbda_pkg::STEP_CNT_BITS-1:0] step_reg, step_next;
    logic [sbda_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                               ovf_reg, ovf_next;
    logic                               valid_reg, valid_next;
    logic                               last_reg, last_next;
    logic [7:0]                         char_reg, char_next;
    logic [PB-1:0]                      mag_reg, mag_next;
    sbda_pkg::bcd_t                     bcd_reg, bcd_next;

    logic [sbda_pkg::VALUE_BITS-1:0]    v_in;
    logic                               neg_in;
    logic [sbda_pkg::VALUE_BITS-1:0]    mag_in;
    logic [3:0]                         top_digit;
    logic                               skip;
    sbda_pkg::unit_out_t                unit_out;

    sbda_bcd_unit u_bcd (
        .bcd    (bcd_reg),
        .bits   (mag_reg[PB-1 -: SB]),
        .result (unit_out)
    );

    assign v_in      = value[sbda_pkg::VALUE_BITS-1:0];
    assign neg_in    = v_in[sbda_pkg::VALUE_BITS-1];
    assign mag_in    = neg_in ? (~v_in + 1'b1) : v_in;
    assign top_digit = bcd_reg[BB-1 -: 4];
    assign skip      = !ovf_reg && (top_digit == 4'd0) && (cnt_reg > 1);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        valid_next = 1'b0;
        last_next  = 1'b0;
        char_next  = char_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mag_next   = PB'(mag_in);
                    bcd_next   = '0;
                    step_next  = '0;
                    ovf_next   = 1'b0;
                    valid_next = neg_in;
                    char_next  = sbda_pkg::CHAR_MINUS;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = unit_out.bcd;
                ovf_next = ovf_reg | unit_out.ovf;
                mag_next = mag_reg << SB;
                step_next = step_reg + 1'b1;
                if (step_reg == sbda_pkg::STEP_CNT_BITS'(sbda_pkg::CONV_STEPS - 1))
                begin
                    cnt_next   = sbda_pkg::CNT_BITS'(sbda_pkg::MAX_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP, ST_EMIT:
            begin
                bcd_next = bcd_reg << 4;
                cnt_next = cnt_reg - 1'b1;
                if (state_reg == ST_EMIT || !skip)
                begin
                    valid_next = 1'b1;
                    char_next  = sbda_pkg::CHAR_ZERO + {4'd0, top_digit};
                    last_next  = (cnt_reg == 1);
                    state_next = (cnt_reg == 1) ? ST_IDLE : ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

    `SBDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SBDA_ASSERT_NOW(a_last_frees, out_valid && last_char, !busy)
    `SBDA_ASSERT_NOW(a_mid_busy, out_valid && !last_char, busy)
    `SBDA_ASSERT_NOW(a_emit_count, state_reg == ST_EMIT, cnt_reg != 0)

endmodule

// File: rtl/sbda_bcd_unit.sv
module sbda_bcd_unit (
    input  sbda_pkg::bcd_t                     bcd,
    input  logic [sbda_pkg::STEP_BITS-1:0]     bits,
    output sbda_pkg::unit_out_t                result
);

    always_comb
    begin
        sbda_pkg::bcd_t b;
        logic           ovf;
        b   = bcd;
        ovf = 1'b0;
        for (int i = 0; i < sbda_pkg::STEP_BITS; i++)
        begin
            for (int d = 0; d < sbda_pkg::MAX_DIGITS; d++)
            begin
                if (b[d*4 +: 4] >= 4'd5)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            ovf = ovf | b[sbda_pkg::BCD_BITS-1];
            b   = {b[sbda_pkg::BCD_BITS-2:0], bits[sbda_pkg::STEP_BITS-1-i]};
        end
        result.bcd = b;
        result.ovf = ovf;
    end

endmodule

// File: verif/signed_binary_to_decimal_ascii_tb.sv
module signed_binary_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_ITEMS  = 33;
    localparam int NUM_DIRECTED  = 18;

    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } glyph_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] value;
    logic        out_valid;
    logic [7:0]  out_char;
    logic        last_char;

    glyph_t pending_chars [$];
    int     mismatches;
    int     cycles;
    int     idle_pct;

    logic [63:0] dir_values [NUM_DIRECTED] = '{
        64'd0,
        64'd1,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'd9,
        64'd10,
        -64'sd10,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0001,
        64'd999999999999999999,
        64'd1000000000000000000,
        -64'sd1000000000000000000,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'd100,
        -64'sd42,
        64'd1234567890123456789,
        64'h0000_0000_FFFF_FFFF
    };

    string dir_texts [NUM_DIRECTED] = '{
        "0",
        "1",
        "-1",
        "9",
        "10",
        "",
        "9223372036854775807",
        "-9223372036854775808",
        "-9223372036854775807",
        "",
        "1000000000000000000",
        "",
        "",
        "",
        "",
        "",
        "",
        ""
    };

    signed_binary_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .out_valid (out_valid),
        .out_char  (out_char),
        .last_char (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void push_decimal_text(input logic [63:0] v);
        logic       negative;
        logic [63:0] magnitude;
        logic [3:0] digits [sbda_pkg::MAX_DIGITS];
        int         count;
        negative  = v[63];
        magnitude = negative ? (~v + 64'd1) : v;
        count     = 0;
        do
        begin
            digits[count] = 4'(magnitude % 64'd10);
            magnitude     = magnitude / 64'd10;
            count++;
        end
        while (magnitude != 64'd0 && count < sbda_pkg::MAX_DIGITS);
        if (negative)
            pending_chars.push_back(glyph_t'{code: sbda_pkg::CHAR_MINUS, is_last: 1'b0});
        for (int k = count - 1; k >= 0; k--)
            pending_chars.push_back(glyph_t'{code: sbda_pkg::CHAR_ZERO + {4'd0, digits[k]},
                                             is_last: (k == 0)});
    endfunction

    function automatic void push_typed_text(input string text);
        for (int i = 0; i < text.len(); i++)
            pending_chars.push_back(glyph_t'{code: text[i], is_last: (i == text.len() - 1)});
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] power;
        int          shape;
        shape = $urandom_range(0, 3);
        unique case (shape)
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 999));
            2: v = {$urandom, $urandom} >> $urandom_range(1, 63);
            default:
            begin
                power = 64'd1;
                repeat ($urandom_range(0, 18)) power = power * 64'd10;
                v = power + 64'($urandom_range(0, 2)) - 64'd1;
            end
        endcase
        if (shape != 0 && $urandom_range(0, 1) == 1)
            v = ~v + 64'd1;
        return v;
    endfunction

    // hold start until the block takes the transaction, then predict
    task automatic send_value(input logic [63:0] v, input string text);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 60)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        if (text.len() > 0)
            push_typed_text(text);
        else
            push_decimal_text(v);
    endtask

    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && out_valid)
        begin
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected character: got %h last %b", out_char, last_char);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_char !== want.code || last_char !== want.is_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("character mismatch: expected %h last %b, got %h last %b",
                                 want.code, want.is_last, out_char, last_char);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int phase_pct [4];
        phase_pct  = '{0, 82, 33, 0};
        rst_n      = 1'b0;
        start      = 1'b0;
        value      = 64'd0;
        mismatches = 0;
        cycles     = 0;
        idle_pct   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(dir_values[i], dir_texts[i]);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_pct[p];
            for (int i = 0; i < RANDOM_ITEMS; i++)
                send_value(random_value(), "");
        end
        start <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_chars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sbda_pkg.sv
rtl/sbda_bcd_unit.sv
rtl/signed_binary_to_decimal_ascii.sv
verif/signed_binary_to_decimal_ascii_tb.sv
